// ===== hw/rtl/bsm_pkg.sv =====
// bsm_pkg: shared types and constants of the bounded substring matcher
// request payload structs, configuration codes and sizing constants
// no dependencies
package bsm_pkg;

	// sizing
	localparam int MAX_SCAN_LENGTH   = 1024;
	localparam int MAX_PATTERN_CHARS = 8;
	localparam int WINDOW_DEPTH      = 8;
	localparam int BYTE_W            = 8;
	localparam int CNT_W             = $clog2(MAX_SCAN_LENGTH + 1);
	localparam int POS_W             = 10;
	localparam int LEN_W             = 4;
	localparam int WIN_IDX_W         = $clog2(WINDOW_DEPTH);
	localparam int PAT_W             = 64;
	localparam int CFG_IDX_W         = 1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_CHARS  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = 1'd1;

	// reset values
	localparam logic [PAT_W-1:0] PATTERN_CHARS_RST  = 64'h0000_0000_0000_4B4F;
	localparam logic [LEN_W-1:0] PATTERN_LENGTH_RST = 4'd2;

	// input request
	typedef struct packed {
		logic [BYTE_W-1:0] data_byte;
		logic              last_byte;
	} bsm_in_t;

	// result request
	typedef struct packed {
		logic             found;
		logic [POS_W-1:0] match_position;
	} bsm_out_t;

	// configuration seen by the scan logic
	typedef struct packed {
		logic [PAT_W-1:0] pattern_chars;
		logic [LEN_W-1:0] pattern_length;
	} bsm_cfg_t;

endpackage

// ===== hw/rtl/bsm_scan.sv =====
// bsm_scan: byte window, byte counter, match tracking and parallel compare
// depends on bsm_pkg
module bsm_scan (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              advance,
	input  bsm_pkg::bsm_in_t  item,
	input  bsm_pkg::bsm_cfg_t cfg,
	output bsm_pkg::bsm_out_t result
);
	import bsm_pkg::*;

	logic [BYTE_W-1:0] window_q [WINDOW_DEPTH];
	logic [BYTE_W-1:0] window_nx [WINDOW_DEPTH];
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  count_nx;
	logic              seen_q;
	logic [POS_W-1:0]  first_q;
	logic [LEN_W-1:0]  eff_len;
	logic              room;
	logic              cmp_ok;
	logic              hit;
	logic [CNT_W-1:0]  start_pos;
	logic [LEN_W-1:0]  age;

	// clamp pattern length to 1..MAX_PATTERN_CHARS
	always_comb begin
		eff_len = cfg.pattern_length;
		if (eff_len == '0)
			eff_len = LEN_W'(1);
		if (eff_len > LEN_W'(MAX_PATTERN_CHARS))
			eff_len = LEN_W'(MAX_PATTERN_CHARS);
	end

	// window after shifting in the new byte
	always_comb begin
		window_nx[0] = item.data_byte;
		for (int i = 1; i < WINDOW_DEPTH; i++)
			window_nx[i] = window_q[i-1];
	end

	assign room     = (count_q < CNT_W'(MAX_SCAN_LENGTH));
	assign count_nx = count_q + CNT_W'(1);

	// compare every pattern character in use against its window slot
	always_comb begin
		cmp_ok = 1'b1;
		age    = '0;
		for (int k = 0; k < MAX_PATTERN_CHARS; k++) begin
			age = eff_len - LEN_W'(1) - LEN_W'(k);
			if (LEN_W'(k) < eff_len &&
				window_nx[age[WIN_IDX_W-1:0]] != cfg.pattern_chars[k*BYTE_W +: BYTE_W])
				cmp_ok = 1'b0;
		end
	end

	assign hit       = room && !seen_q && (count_nx >= CNT_W'(eff_len)) && cmp_ok;
	assign start_pos = count_nx - CNT_W'(eff_len);

	// result for a final byte, taken by the output register
	always_comb begin
		result.found          = seen_q || hit;
		result.match_position = seen_q ? first_q : (hit ? start_pos[POS_W-1:0] : '0);
	end

	// buffer state, cleared after every final byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WINDOW_DEPTH; i++)
				window_q[i] <= '0;
			count_q <= '0;
			seen_q  <= 1'b0;
			first_q <= '0;
		end else if (advance) begin
			if (item.last_byte) begin
				for (int i = 0; i < WINDOW_DEPTH; i++)
					window_q[i] <= '0;
				count_q <= '0;
				seen_q  <= 1'b0;
				first_q <= '0;
			end else if (room) begin
				window_q <= window_nx;
				count_q  <= count_nx;
				if (hit) begin
					seen_q  <= 1'b1;
					first_q <= start_pos[POS_W-1:0];
				end
			end
		end
	end

endmodule

// ===== hw/rtl/bsm_out_reg.sv =====
// bsm_out_reg: result register of the matcher, holds a result while stalled
// depends on bsm_pkg
module bsm_out_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  bsm_pkg::bsm_out_t result,
	input  logic              stall,
	output logic              valid,
	output logic              free,
	output bsm_pkg::bsm_out_t data
);
	import bsm_pkg::*;

	logic     valid_q;
	bsm_out_t data_q;

	// room for a new result when empty or being taken this cycle
	assign free  = !valid_q || !stall;
	assign valid = valid_q;
	assign data  = data_q;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!stall) begin
			valid_q <= 1'b0;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (load)
			data_q <= result;
	end

endmodule

// ===== hw/rtl/bounded_substring_matcher.sv =====
// bounded_substring_matcher: top level of the streaming pattern matcher
// input register, configuration registers, scan logic and result register
// depends on bsm_pkg, bsm_scan, bsm_out_reg
//
// Usage: bytes of one buffer arrive on the in channel, one request per byte,
// the final byte marked by last_byte. After the final byte one request leaves
// on the out channel: found and the start offset of the first full match of
// the pattern (0 when not found). Other bytes give no result.
// The pattern (up to 8 characters, first in the low byte) and its length are
// written through cfg_we/cfg_index/cfg_data while no buffer is in flight.
// A final byte passes through the input register into the result register.
// Throughput: one byte per cycle unless a final byte is held, set by the window
// compare, combinational between the input register and the result register.
// Receiver stall: a pending result is held; non-final bytes keep flowing,
// and a final byte waits in the input register, which then stalls the sender.
// Bytes past 1024 in a buffer are dropped from the search.
// Reset: window, counters and both channels empty; pattern "OK", length 2.
module bounded_substring_matcher (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  bsm_pkg::bsm_in_t              in_data,
	output logic                          out_valid,
	input  logic                          out_stall,
	output bsm_pkg::bsm_out_t             out_data,
	input  logic                          cfg_we,
	input  logic [bsm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bsm_pkg::PAT_W-1:0]     cfg_data
);
	import bsm_pkg::*;

	logic     valid_s1;
	bsm_in_t  item_s1;
	logic     go_s1;
	logic     out_free;
	logic     load_out;
	bsm_cfg_t cfg_q;
	bsm_out_t scan_result;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pattern_chars  <= PATTERN_CHARS_RST;
			cfg_q.pattern_length <= PATTERN_LENGTH_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_PATTERN_CHARS:  cfg_q.pattern_chars  <= cfg_data;
				CFG_PATTERN_LENGTH: cfg_q.pattern_length <= cfg_data[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	// input stage moves on unless a final byte finds the result register full
	assign go_s1    = valid_s1 && (!item_s1.last_byte || out_free);
	assign in_stall = valid_s1 && !go_s1;
	assign load_out = go_s1 && item_s1.last_byte;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (go_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall)
			item_s1 <= in_data;
	end

	// window compare and buffer state
	bsm_scan u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.advance(go_s1),
		.item   (item_s1),
		.cfg    (cfg_q),
		.result (scan_result)
	);

	// result register
	bsm_out_reg u_out (
		.clk   (clk),
		.arst_n(arst_n),
		.load  (load_out),
		.result(scan_result),
		.stall (out_stall),
		.valid (out_valid),
		.free  (out_free),
		.data  (out_data)
	);

	// the sender is only held off by a final byte waiting on the result register
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && item_s1.last_byte && out_valid && out_stall))
		else $error("input stalled without a blocked final byte");

	// a final byte that moves on always leaves a result behind
	a_final_result: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> out_valid)
		else $error("final byte produced no result");

	// a miss carries offset zero
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_data.found) |-> (out_data.match_position == '0))
		else $error("nonzero offset without a match");

endmodule

// ===== verif/tb_bounded_substring_matcher.sv =====
`timescale 1ns / 100ps
// tb_bounded_substring_matcher: self-checking testbench of the substring matcher
// streams byte buffers with random gaps and stalls, predicts found and position
// depends on bsm_pkg and bounded_substring_matcher
module tb_bounded_substring_matcher;
	import bsm_pkg::*;

	localparam int ITEM_TARGET = 600;
	localparam longint TIMEOUT_NS = 40_000_000;

	// tracks the scan of the current buffer and the pending match results
	class match_scoreboard;
		logic [PAT_W-1:0]  pat_chars;
		logic [LEN_W-1:0]  pat_len;
		logic [BYTE_W-1:0] recent [WINDOW_DEPTH];
		int                scanned;
		bit                hit;
		int                hit_start;
		bsm_out_t          match_results_q [$];
		int                errors;

		function new();
			pat_chars = PATTERN_CHARS_RST;
			pat_len = PATTERN_LENGTH_RST;
			errors = 0;
			clear_scan();
		endfunction

		function void clear_scan();
			foreach (recent[i])
				recent[i] = '0;
			scanned = 0;
			hit = 0;
			hit_start = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [PAT_W-1:0] data);
			if (idx == CFG_PATTERN_CHARS)
				pat_chars = data;
			else
				pat_len = data[LEN_W-1:0];
		endfunction

		// length zero counts as one, anything past the window as the window
		function int active_len();
			if (pat_len == 0)
				return 1;
			if (pat_len > MAX_PATTERN_CHARS)
				return MAX_PATTERN_CHARS;
			return pat_len;
		endfunction

		// oldest window byte lines up with the first pattern character
		function bit window_hit(int len);
			for (int k = 0; k < len; k++) begin
				if (recent[len - 1 - k] != pat_chars[8*k +: 8])
					return 0;
			end
			return 1;
		endfunction

		function void note_byte(bsm_in_t req);
			int len;
			bsm_out_t res;
			// bytes past the scan limit are dropped
			if (scanned < MAX_SCAN_LENGTH) begin
				len = active_len();
				for (int i = WINDOW_DEPTH - 1; i > 0; i--)
					recent[i] = recent[i-1];
				recent[0] = req.data_byte;
				scanned++;
				if (!hit && scanned >= len && window_hit(len)) begin
					hit = 1;
					hit_start = scanned - len;
				end
			end
			// final byte closes the buffer
			if (req.last_byte) begin
				res.found = hit;
				res.match_position = hit ? POS_W'(hit_start) : '0;
				match_results_q.push_back(res);
				clear_scan();
			end
		endfunction

		function void check_result(bsm_out_t got);
			bsm_out_t want;
			if (match_results_q.size() == 0) begin
				$error("result request with no buffer pending: found %0d position %0d",
					got.found, got.match_position);
				errors++;
				return;
			end
			want = match_results_q.pop_front();
			if (got.found !== want.found) begin
				$error("found: expected %0d, got %0d", want.found, got.found);
				errors++;
			end
			if (got.match_position !== want.match_position) begin
				$error("match_position: expected %0d, got %0d",
					want.match_position, got.match_position);
				errors++;
			end
		endfunction

		function int pending();
			return match_results_q.size();
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	bsm_in_t              in_data = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	bsm_out_t             out_data;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_PATTERN_CHARS;
	logic [PAT_W-1:0]     cfg_data = '0;

	match_scoreboard sb = new();

	logic [BYTE_W-1:0] scan_buf [$];
	logic [PAT_W-1:0]  cur_chars = PATTERN_CHARS_RST;
	logic [LEN_W-1:0]  cur_len = PATTERN_LENGTH_RST;
	int                items_sent = 0;
	bit                calm = 0;

	bounded_substring_matcher dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// mostly short gaps, a few long ones
	function int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function int active_len();
		if (cur_len == 0)
			return 1;
		if (cur_len > MAX_PATTERN_CHARS)
			return MAX_PATTERN_CHARS;
		return cur_len;
	endfunction

	function bit in_pattern(logic [BYTE_W-1:0] b);
		for (int k = 0; k < active_len(); k++) begin
			if (cur_chars[8*k +: 8] == b)
				return 1;
		end
		return 0;
	endfunction

	// half the bytes come from the pattern so partial matches are common
	function logic [BYTE_W-1:0] pick_char();
		if ($urandom_range(0, 1))
			return cur_chars[8*$urandom_range(0, active_len() - 1) +: 8];
		return BYTE_W'($urandom);
	endfunction

	task automatic set_pattern(input logic [PAT_W-1:0] chars, input logic [LEN_W-1:0] len);
		cfg_we <= 1'b1;
		cfg_index <= CFG_PATTERN_CHARS;
		cfg_data <= chars;
		@(posedge clk);
		sb.write_reg(CFG_PATTERN_CHARS, chars);
		cfg_index <= CFG_PATTERN_LENGTH;
		cfg_data <= {{(PAT_W-LEN_W){1'b0}}, len};
		@(posedge clk);
		sb.write_reg(CFG_PATTERN_LENGTH, {{(PAT_W-LEN_W){1'b0}}, len});
		cfg_we <= 1'b0;
		cur_chars = chars;
		cur_len = len;
	endtask

	// hold off the sender until every result is back and the pipe is empty
	task automatic settle();
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic send_byte(input logic [BYTE_W-1:0] b, input bit last);
		int gap;
		bsm_in_t req;
		gap = calm ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			in_data <= bsm_in_t'($urandom);
			repeat (gap) @(posedge clk);
		end
		req.data_byte = b;
		req.last_byte = last;
		in_valid <= 1'b1;
		in_data <= req;
		@(posedge clk);
		while (in_stall !== 1'b0)
			@(posedge clk);
		sb.note_byte(req);
		items_sent++;
	endtask

	task automatic send_buffer();
		foreach (scan_buf[i])
			send_byte(scan_buf[i], i == scan_buf.size() - 1);
	endtask

	// random fill, pattern dropped in at a given offset (may run off the end)
	task automatic build_buffer(input int n, input bit embed, input int at);
		scan_buf.delete();
		for (int i = 0; i < n; i++)
			scan_buf.push_back(pick_char());
		if (embed) begin
			for (int k = 0; k < active_len(); k++) begin
				if (at + k < n)
					scan_buf[at + k] = cur_chars[8*k +: 8];
			end
		end
	endtask

	// fill with bytes that never occur in the pattern
	task automatic build_foreign(input int n);
		logic [BYTE_W-1:0] b;
		scan_buf.delete();
		for (int i = 0; i < n; i++) begin
			b = BYTE_W'($urandom);
			while (in_pattern(b))
				b = BYTE_W'($urandom);
			scan_buf.push_back(b);
		end
	endtask

	function logic [PAT_W-1:0] nonzero_chars();
		logic [PAT_W-1:0] c;
		c = {$urandom, $urandom};
		for (int k = 0; k < 8; k++) begin
			if (c[8*k +: 8] == 0)
				c[8*k +: 8] = BYTE_W'($urandom_range(1, 255));
		end
		return c;
	endfunction

	task automatic random_config();
		logic [PAT_W-1:0] chars;
		logic [LEN_W-1:0] len;
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			chars = '1;
		else if (r == 1)
			chars = {8{8'h01}};
		else
			chars = nonzero_chars();
		// a literal zero character now and then
		if (r == 2)
			chars[8*$urandom_range(0, 7) +: 8] = 8'h00;
		r = $urandom_range(0, 19);
		if (r == 0)
			len = 0;
		else if (r == 1)
			len = LEN_W'($urandom_range(9, 15));
		else
			len = LEN_W'($urandom_range(1, 8));
		set_pattern(chars, len);
	endtask

	// result side: random stall bursts, checks every accepted result
	initial begin
		int stall_left;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (out_valid === 1'b1 && out_stall === 1'b0)
				sb.check_result(out_data);
			if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else begin
				out_stall <= 1'b0;
				if (!calm)
					stall_left = pick_gap();
			end
		end
	end

	// main sequence
	initial begin
		int n;
		int nbuf;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset pattern "OK": match at start, short buffers, repeated match
		scan_buf = {8'h4F, 8'h4B};
		send_buffer();
		scan_buf = {8'h4B};
		send_buffer();
		scan_buf = {8'h4F};
		send_buffer();
		scan_buf = {8'h78, 8'h4F, 8'h4B, 8'h4F, 8'h4B};
		send_buffer();
		scan_buf = {8'hFF, 8'h00};
		send_buffer();

		// full eight character pattern
		settle();
		set_pattern(64'h2154_4345_4E4E_4F43, 4'd8);
		scan_buf = {8'h43, 8'h4F, 8'h4E, 8'h4E, 8'h45, 8'h43, 8'h54, 8'h21};
		send_buffer();

		// length zero acts as one, zero character compared literally
		settle();
		set_pattern(64'hFFFF_FFFF_FFFF_FF00, 4'd0);
		scan_buf = {8'h41, 8'h00};
		send_buffer();

		// oversize length acts as eight, window never fills
		settle();
		set_pattern(64'h0102_0304_0506_0708, 4'd15);
		scan_buf = {8'h08, 8'h07, 8'h06, 8'h05};
		send_buffer();

		// random phases: new pattern, then a handful of buffers
		while (items_sent < ITEM_TARGET) begin
			settle();
			random_config();
			nbuf = $urandom_range(2, 6);
			for (int b = 0; b < nbuf; b++) begin
				calm = ($urandom_range(0, 4) == 0);
				n = ($urandom_range(0, 9) != 0) ? $urandom_range(1, 24) : $urandom_range(25, 80);
				build_buffer(n, $urandom_range(0, 4) != 0, $urandom_range(0, n - 1));
				send_buffer();
			end
		end
		calm = 0;

		// long buffers: last position before the scan limit, and past it
		settle();
		set_pattern(nonzero_chars(), 4'd1);
		build_foreign(1030);
		scan_buf[1023] = cur_chars[7:0];
		scan_buf[1026] = cur_chars[7:0];
		send_buffer();

		settle();
		set_pattern(nonzero_chars(), 4'd4);
		build_foreign(1030);
		for (int k = 0; k < 4; k++)
			scan_buf[1021 + k] = cur_chars[8*k +: 8];
		send_buffer();
		build_foreign(1040);
		for (int k = 0; k < 4; k++)
			scan_buf[1020 + k] = cur_chars[8*k +: 8];
		send_buffer();

		// drain and finish
		settle();
		repeat (10) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	// watchdog
	initial begin
		#(TIMEOUT_NS);
		$display("TEST FAILED");
		$finish;
	end

endmodule
